FILE: src/boa_pkg.sv
`default_nettype none
package boa_pkg;

    localparam int WordBits = 16;
    localparam int DivSteps = 2 * WordBits;

    // basic operation codes
    typedef enum logic [4:0] {
        OP_SET = 5'd0,  OP_ADD = 5'd1,  OP_SUB = 5'd2,  OP_MUL = 5'd3,
        OP_MLI = 5'd4,  OP_DIV = 5'd5,  OP_DVI = 5'd6,  OP_MOD = 5'd7,
        OP_MDI = 5'd8,  OP_AND = 5'd9,  OP_BOR = 5'd10, OP_XOR = 5'd11,
        OP_SHR = 5'd12, OP_ASR = 5'd13, OP_SHL = 5'd14, OP_IFB = 5'd15,
        OP_IFC = 5'd16, OP_IFE = 5'd17, OP_IFN = 5'd18, OP_IFG = 5'd19,
        OP_IFA = 5'd20, OP_IFL = 5'd21, OP_IFU = 5'd22, OP_ADX = 5'd23,
        OP_SBX = 5'd24, OP_STI = 5'd25, OP_STD = 5'd26
    } t_op;

    localparam logic [1:0] StepNone = 2'b00;
    localparam logic [1:0] StepInc  = 2'b01;
    localparam logic [1:0] StepDec  = 2'b11;

    // payload carried down the pipeline
    typedef struct packed {
        t_op                 op;
        logic                div_zero;
        logic [WordBits-1:0] divisor;
        logic [WordBits-1:0] rem;
        logic [DivSteps-1:0] dvd;
        logic [WordBits-1:0] rem_hold;
        logic                neg_q;
        logic                neg_r;
        logic [WordBits-1:0] b_res;
        logic [WordBits-1:0] ex_res;
        logic                b_wr;
        logic                ex_wr;
        logic                skip;
        logic [1:0]          step;
        logic [1:0]          cost;
    } t_stage;

endpackage
`default_nettype wire

FILE: src/boa_req_if.sv
`default_nettype none
interface boa_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [15:0] a_value;
    logic [15:0] b_value;
    logic [15:0] ex_in;

    modport source (output valid, req_type, a_value, b_value, ex_in, input ready);
    modport sink   (input valid, req_type, a_value, b_value, ex_in, output ready);
endinterface
`default_nettype wire

FILE: src/boa_rsp_if.sv
`default_nettype none
interface boa_rsp_if;
    logic              valid;
    logic              ready;
    logic [15:0]       b_result;
    logic              b_write;
    logic [15:0]       ex_result;
    logic              ex_write;
    logic              skip_next;
    logic signed [1:0] index_step;
    logic [1:0]        cost_cycles;

    modport source (output valid, b_result, b_write, ex_result, ex_write, skip_next,
                    index_step, cost_cycles, input ready);
    modport sink   (input valid, b_result, b_write, ex_result, ex_write, skip_next,
                    index_step, cost_cycles, output ready);
endinterface
`default_nettype wire

FILE: src/boa_front.sv
`default_nettype none
module boa_front
    import boa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [4:0]  i_op,
    input  wire logic [15:0] i_a,
    input  wire logic [15:0] i_b,
    input  wire logic [15:0] i_ex,
    output logic             o_valid,
    output t_stage           o_stage
);
    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    logic [16:0] sum;
    logic [17:0] adx_sum;
    logic [17:0] sbx_diff;
    logic [31:0] prod;
    logic [31:0] wide_r;
    logic [47:0] wide_l;
    logic [15:0] mag_a;
    logic [15:0] mag_b;
    logic        big_shift;
    logic        signed_div;
    t_op         op;

    always_comb begin
        op         = t_op'(i_op);
        sum        = {1'b0, i_b} + {1'b0, i_a};
        adx_sum    = {2'b00, i_b} + {2'b00, i_a} + {2'b00, i_ex};
        sbx_diff   = {2'b00, i_b} - {2'b00, i_a} + {2'b00, i_ex};
        big_shift  = |i_a[15:5];
        signed_div = (op == OP_DVI) || (op == OP_MDI);
        mag_a      = (signed_div && i_a[15]) ? 16'(-i_a) : i_a;
        mag_b      = (signed_div && i_b[15]) ? 16'(-i_b) : i_b;
    end

    // single shared multiplier, signed or unsigned
    always_comb begin
        if (op == OP_MLI) begin
            prod = $signed({{16{i_b[15]}}, i_b}) * $signed({{16{i_a[15]}}, i_a});
        end else begin
            prod = {16'h0000, i_b} * {16'h0000, i_a};
        end
    end

    // shifter over a double-width word
    always_comb begin
        if (op == OP_ASR) begin
            wide_r = big_shift ? {32{i_b[15]}} : 32'($signed({i_b, 16'h0000}) >>> i_a[4:0]);
        end else begin
            wide_r = big_shift ? 32'h0 : ({i_b, 16'h0000} >> i_a[4:0]);
        end
        wide_l = big_shift ? 48'h0 : ({32'h0, i_b} << i_a[4:0]);
    end

    // decode and non-divide results
    always_comb begin
        n_stage          = '0;
        n_stage.op       = op;
        n_stage.div_zero = (i_a == 16'h0);
        n_stage.divisor  = mag_a;
        n_stage.dvd      = {mag_b, 16'h0000};
        n_stage.neg_q    = i_a[15] ^ i_b[15];
        n_stage.neg_r    = i_b[15];
        n_stage.step     = StepNone;
        n_stage.cost     = 2'd1;
        case (op)
            OP_SET: begin n_stage.b_res = i_a; n_stage.b_wr = 1'b1; end
            OP_ADD: begin
                n_stage.b_res = sum[15:0]; n_stage.ex_res = {15'h0, sum[16]};
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd2;
            end
            OP_SUB: begin
                n_stage.b_res = 16'(i_b - i_a);
                n_stage.ex_res = (i_b < i_a) ? 16'hffff : 16'h0;
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd2;
            end
            OP_MUL, OP_MLI: begin
                n_stage.b_res = prod[15:0]; n_stage.ex_res = prod[31:16];
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd2;
            end
            OP_DIV, OP_DVI: begin
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd3;
            end
            OP_MOD, OP_MDI: begin n_stage.b_wr = 1'b1; n_stage.cost = 2'd3; end
            OP_AND: begin n_stage.b_res = i_a & i_b; n_stage.b_wr = 1'b1; end
            OP_BOR: begin n_stage.b_res = i_a | i_b; n_stage.b_wr = 1'b1; end
            OP_XOR: begin n_stage.b_res = i_a ^ i_b; n_stage.b_wr = 1'b1; end
            OP_SHR, OP_ASR: begin
                n_stage.b_res = wide_r[31:16]; n_stage.ex_res = wide_r[15:0];
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1;
            end
            OP_SHL: begin
                n_stage.b_res = wide_l[15:0]; n_stage.ex_res = wide_l[31:16];
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1;
            end
            OP_IFB: n_stage.skip = ((i_a & i_b) == 16'h0);
            OP_IFC: n_stage.skip = ((i_a & i_b) != 16'h0);
            OP_IFE: n_stage.skip = (i_a != i_b);
            OP_IFN: n_stage.skip = (i_a == i_b);
            OP_IFG: n_stage.skip = !(i_b > i_a);
            OP_IFA: n_stage.skip = !($signed(i_b) > $signed(i_a));
            OP_IFL: n_stage.skip = !(i_b < i_a);
            OP_IFU: n_stage.skip = !($signed(i_b) < $signed(i_a));
            OP_ADX: begin
                n_stage.b_res = adx_sum[15:0];
                n_stage.ex_res = (adx_sum[17:16] != 2'b00) ? 16'h0001 : 16'h0;
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd3;
            end
            OP_SBX: begin
                n_stage.b_res = sbx_diff[15:0];
                if (sbx_diff[17]) begin
                    n_stage.ex_res = 16'hffff;
                end else if (sbx_diff[16]) begin
                    n_stage.ex_res = 16'h0001;
                end
                n_stage.b_wr = 1'b1; n_stage.ex_wr = 1'b1; n_stage.cost = 2'd3;
            end
            OP_STI: begin
                n_stage.b_res = i_a; n_stage.b_wr = 1'b1;
                n_stage.step = StepInc; n_stage.cost = 2'd2;
            end
            OP_STD: begin
                n_stage.b_res = i_a; n_stage.b_wr = 1'b1;
                n_stage.step = StepDec; n_stage.cost = 2'd2;
            end
            default: ;
        endcase
        if (op == OP_IFB || op == OP_IFC || op == OP_IFE || op == OP_IFN ||
            op == OP_IFG || op == OP_IFA || op == OP_IFL || op == OP_IFU) begin
            n_stage.cost = n_stage.skip ? 2'd3 : 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule
`default_nettype wire

FILE: src/boa_div_step.sv
`default_nettype none
module boa_div_step
    import boa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_capture,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_stage      o_stage
);
    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    logic [16:0] trial;
    logic [17:0] diff;

    // one restoring division step: one quotient bit
    always_comb begin
        trial   = {i_stage.rem, i_stage.dvd[DivSteps-1]};
        diff    = {1'b0, trial} - {2'b00, i_stage.divisor};
        n_stage = i_stage;
        if (!diff[17]) begin
            n_stage.rem = diff[15:0];
        end else begin
            n_stage.rem = trial[15:0];
        end
        n_stage.dvd = {i_stage.dvd[DivSteps-2:0], !diff[17]};
        if (i_capture) begin
            n_stage.rem_hold = n_stage.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule
`default_nettype wire

FILE: src/basic_opcode_alu_16bit_unit.sv
`default_nettype none
// DCPU-16 basic instruction execute unit. One instruction is accepted per
// cycle unless the output stalls. Its result passes through one decode stage
// that also produces every non-divide result, 32 restoring divider stages
// (one quotient bit each, the remainder for MOD/MDI is taken after the
// 16th) and an output register that forms the divide results. The pipeline
// moves as a whole whenever the output register is empty or being read, so
// a stall at the output holds every stage in place.
module basic_opcode_alu_16bit_unit
    import boa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    boa_req_if.sink   i_req,
    boa_rsp_if.source o_rsp
);
    logic   en;
    logic   v [DivSteps+1];
    t_stage s [DivSteps+1];

    logic              r_out_valid;
    logic [15:0]       r_b_result;
    logic              r_b_write;
    logic [15:0]       r_ex_result;
    logic              r_ex_write;
    logic              r_skip_next;
    logic [1:0]        r_index_step;
    logic [1:0]        r_cost_cycles;
    logic [15:0]       n_b_result;
    logic [15:0]       n_ex_result;
    logic [15:0]       quot;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    boa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_op    (i_req.req_type),
        .i_a     (i_req.a_value),
        .i_b     (i_req.b_value),
        .i_ex    (i_req.ex_in),
        .o_valid (v[0]),
        .o_stage (s[0])
    );

    // divider chain
    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        boa_div_step u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_capture (g == WordBits - 1),
            .i_valid   (v[g]),
            .i_stage   (s[g]),
            .o_valid   (v[g+1]),
            .o_stage   (s[g+1])
        );
    end

    // final result select
    always_comb begin
        quot        = s[DivSteps].neg_q ? 16'(-s[DivSteps].dvd[15:0]) : s[DivSteps].dvd[15:0];
        n_b_result  = s[DivSteps].b_res;
        n_ex_result = s[DivSteps].ex_res;
        case (s[DivSteps].op)
            OP_DIV: begin
                n_b_result  = s[DivSteps].dvd[31:16];
                n_ex_result = s[DivSteps].dvd[15:0];
            end
            OP_DVI: begin
                // integer part negated on its own so it truncates toward zero
                n_b_result  = s[DivSteps].neg_q ? 16'(-s[DivSteps].dvd[31:16])
                                                : s[DivSteps].dvd[31:16];
                n_ex_result = quot;
            end
            OP_MOD: n_b_result = s[DivSteps].rem_hold;
            OP_MDI: n_b_result = s[DivSteps].neg_r ? 16'(-s[DivSteps].rem_hold)
                                                   : s[DivSteps].rem_hold;
            default: ;
        endcase
        if ((s[DivSteps].op == OP_DIV || s[DivSteps].op == OP_DVI ||
             s[DivSteps].op == OP_MOD || s[DivSteps].op == OP_MDI) &&
            s[DivSteps].div_zero) begin
            n_b_result  = 16'h0;
            n_ex_result = 16'h0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_result    <= n_b_result;
            r_b_write     <= s[DivSteps].b_wr;
            r_ex_result   <= n_ex_result;
            r_ex_write    <= s[DivSteps].ex_wr;
            r_skip_next   <= s[DivSteps].skip;
            r_index_step  <= s[DivSteps].step;
            r_cost_cycles <= s[DivSteps].cost;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.b_result    = r_b_result;
    assign o_rsp.b_write     = r_b_write;
    assign o_rsp.ex_result   = r_ex_result;
    assign o_rsp.ex_write    = r_ex_write;
    assign o_rsp.skip_next   = r_skip_next;
    assign o_rsp.index_step  = $signed(r_index_step);
    assign o_rsp.cost_cycles = r_cost_cycles;
endmodule
`default_nettype wire
